[src/mpt_pkg.sv]
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants for the mains period tracker: register
// indexes, reset values, button windows and reciprocal constants.
// ----------------------------------------------------------------------------
package mpt_pkg;

  // Field widths
  localparam int unsigned SampleW  = 10;
  localparam int unsigned PeriodW  = 13;
  localparam int unsigned DelayW   = 12;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned VoltW    = 11;
  localparam int unsigned CodeW    = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CROSSING_LEVEL = 2'd0,
    CFG_NOMINAL_PERIOD = 2'd1,
    CFG_PERIOD_MARGIN  = 2'd2,
    CFG_BUTTON_DELAY   = 2'd3
  } cfg_index_t;

  // Register and state reset values
  localparam logic [9:0]         RstCrossingLevel = 10'd465;
  localparam logic [11:0]        RstNominalPeriod = 12'd2499;
  localparam logic [9:0]         RstPeriodMargin  = 10'd200;
  localparam logic [11:0]        RstButtonDelay   = 12'd999;
  localparam logic [PeriodW-1:0] RstPeriod        = 13'd2499;

  // Button ladder windows (inclusive), compared on 11 bits
  localparam logic [10:0] MenuLo = 11'd480;
  localparam logic [10:0] MenuHi = 11'd520;
  localparam logic [10:0] DownLo = 11'd658;
  localparam logic [10:0] DownHi = 11'd698;
  localparam logic [10:0] UpLo   = 11'd1000;
  localparam logic [10:0] UpHi   = 11'd1040;

  // Button classes
  localparam logic [CodeW-1:0] BtnNone = 2'd0;
  localparam logic [CodeW-1:0] BtnMenu = 2'd1;
  localparam logic [CodeW-1:0] BtnDown = 2'd2;
  localparam logic [CodeW-1:0] BtnUp   = 2'd3;

  // x/10 = (x * 52429) >> 19, exact for x < 2^18
  localparam logic [15:0] Recip10      = 16'd52429;
  localparam int unsigned Recip10Shift = 19;
  // x/3 = (x * 2731) >> 13, exact for x < 2^13
  localparam logic [11:0] Recip3       = 12'd2731;
  localparam int unsigned Recip3Shift  = 13;

  // Crossing-phase update result
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] average;
  } period_upd_t;

  // Button decode result
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [VoltW-1:0] voltage;
  } button_info_t;

endpackage

[src/mpt_period_calc.sv]
// ----------------------------------------------------------------------------
// mpt_period_calc
// Crossing-phase arithmetic: new timer period from the running average and
// the sample, then the filtered and clamped average.
// ----------------------------------------------------------------------------
module mpt_period_calc (
  input  logic [mpt_pkg::SampleW-1:0] adc_sample,
  input  logic [mpt_pkg::PeriodW-1:0] period_average,
  input  logic [9:0]                  crossing_level,
  input  logic [11:0]                 nominal_period,
  input  logic [9:0]                  period_margin,
  output mpt_pkg::period_upd_t        upd
);

  logic [13:0]                 sum;
  logic [13:0]                 diff;
  logic [mpt_pkg::PeriodW-1:0] period;
  logic [16:0]                 acc;
  logic [32:0]                 prod;
  logic [mpt_pkg::PeriodW-1:0] quot;
  logic [mpt_pkg::PeriodW-1:0] hi;
  logic [11:0]                 lo;
  logic [mpt_pkg::PeriodW-1:0] avg_hi;

  // Period = average + crossing level - sample, floored at zero
  assign sum    = {1'b0, period_average} + {4'b0, crossing_level};
  assign diff   = (sum > {4'b0, adc_sample}) ? (sum - {4'b0, adc_sample}) : 14'd0;
  assign period = diff[mpt_pkg::PeriodW-1:0];

  // (9*average + period) / 10 by reciprocal multiply
  assign acc  = {1'b0, period_average, 3'b000} + {4'b0, period_average} + {4'b0, period};
  assign prod = acc * mpt_pkg::Recip10;
  assign quot = prod[mpt_pkg::Recip10Shift +: mpt_pkg::PeriodW];

  // Clamp bounds; lower bound floors at zero
  assign hi = {1'b0, nominal_period} + {3'b0, period_margin};
  assign lo = (nominal_period > {2'b0, period_margin}) ?
              (nominal_period - {2'b0, period_margin}) : 12'd0;

  // Upper bound first, then lower
  assign avg_hi = (quot > hi) ? hi : quot;

  always_comb begin
    upd.period  = period;
    upd.average = (avg_hi < {1'b0, lo}) ? {1'b0, lo} : avg_hi;
  end

endmodule

[src/mpt_button_decode.sv]
// ----------------------------------------------------------------------------
// mpt_button_decode
// Classifies the button-ladder sample by voltage window and scales it to
// the voltage reading (sample * 4 / 3).
// ----------------------------------------------------------------------------
module mpt_button_decode (
  input  logic [mpt_pkg::SampleW-1:0] button_sample,
  output mpt_pkg::button_info_t       info
);

  logic [10:0] s_ext;
  logic [11:0] scaled;
  logic [23:0] prod;

  assign s_ext = {1'b0, button_sample};

  // sample*4/3 by reciprocal multiply
  assign scaled = {button_sample, 2'b00};
  assign prod   = scaled * mpt_pkg::Recip3;

  // Window classification and scaled voltage
  always_comb begin
    priority if (s_ext >= mpt_pkg::MenuLo && s_ext <= mpt_pkg::MenuHi) begin
      info.code = mpt_pkg::BtnMenu;
    end else if (s_ext >= mpt_pkg::DownLo && s_ext <= mpt_pkg::DownHi) begin
      info.code = mpt_pkg::BtnDown;
    end else if (s_ext >= mpt_pkg::UpLo && s_ext <= mpt_pkg::UpHi) begin
      info.code = mpt_pkg::BtnUp;
    end else begin
      info.code = mpt_pkg::BtnNone;
    end
    info.voltage = prod[mpt_pkg::Recip3Shift +: mpt_pkg::VoltW];
  end

endmodule

[src/mains_period_tracker_with_button_adc.sv]
// Pipeline: two register stages (input, then result); an item moves from the
//   input register to the result register once that is empty or being taken.
// Throughput: one item per cycle unless out_stall holds; the phase (and in
//   crossing phase, average and period) updates as an item enters the result register.
// Reset (rst, synchronous): registers to defaults, button phase first,
//   average and period to 2499, both pipeline stages empty.
// ----------------------------------------------------------------------------
// mains_period_tracker_with_button_adc
// Alternating button/zero-crossing ADC handler: stores the button sample,
// tracks the mains period and decodes the button ladder.
// ----------------------------------------------------------------------------
module mains_period_tracker_with_button_adc (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [mpt_pkg::CfgDataW-1:0] cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mpt_pkg::SampleW-1:0] adc_sample,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mpt_pkg::PeriodW-1:0] period_top,
  output logic [mpt_pkg::DelayW-1:0]  trigger_delay,
  output logic                        next_channel,
  output logic [mpt_pkg::CodeW-1:0]   button_code,
  output logic [mpt_pkg::VoltW-1:0]   voltage_value,
  output logic                        motor_refresh
);

  // Configuration registers
  logic [9:0]  crossing_level;
  logic [11:0] nominal_period;
  logic [9:0]  period_margin;
  logic [11:0] button_delay;

  // Block state
  logic                        in_button_phase;
  logic [mpt_pkg::SampleW-1:0] button_sample;
  logic [mpt_pkg::PeriodW-1:0] period_average;
  logic [mpt_pkg::PeriodW-1:0] current_period;

  // Input register
  logic                        in_reg_valid;
  logic [mpt_pkg::SampleW-1:0] in_reg_sample;

  logic                        advance;
  logic [mpt_pkg::SampleW-1:0] button_sample_next;
  mpt_pkg::period_upd_t        upd;
  mpt_pkg::button_info_t       info;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_level <= mpt_pkg::RstCrossingLevel;
      nominal_period <= mpt_pkg::RstNominalPeriod;
      period_margin  <= mpt_pkg::RstPeriodMargin;
      button_delay   <= mpt_pkg::RstButtonDelay;
    end else if (cfg_write) begin
      unique case (mpt_pkg::cfg_index_t'(cfg_index))
        mpt_pkg::CFG_CROSSING_LEVEL: crossing_level <= cfg_data[9:0];
        mpt_pkg::CFG_NOMINAL_PERIOD: nominal_period <= cfg_data[11:0];
        mpt_pkg::CFG_PERIOD_MARGIN:  period_margin  <= cfg_data[9:0];
        mpt_pkg::CFG_BUTTON_DELAY:   button_delay   <= cfg_data[11:0];
      endcase
    end
  end

  // Handshake: result register frees when empty or taken
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_sample <= adc_sample;
    end
  end

  // Datapath
  mpt_period_calc u_period_calc (
    .adc_sample     (in_reg_sample),
    .period_average (period_average),
    .crossing_level (crossing_level),
    .nominal_period (nominal_period),
    .period_margin  (period_margin),
    .upd            (upd)
  );

  assign button_sample_next = in_button_phase ? in_reg_sample : button_sample;

  mpt_button_decode u_button_decode (
    .button_sample (button_sample_next),
    .info          (info)
  );

  // State update on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_button_phase <= 1'b1;
      button_sample   <= '0;
      period_average  <= mpt_pkg::RstPeriod;
      current_period  <= mpt_pkg::RstPeriod;
    end else if (advance) begin
      in_button_phase <= !in_button_phase;
      button_sample   <= button_sample_next;
      if (!in_button_phase) begin
        period_average <= upd.average;
        current_period <= upd.period;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      period_top    <= in_button_phase ? current_period : upd.period;
      trigger_delay <= in_button_phase ? '0 : button_delay;
      next_channel  <= in_button_phase;
      motor_refresh <= in_button_phase;
      button_code   <= info.code;
      voltage_value <= info.voltage;
    end
  end

`ifndef SYNTHESIS
  // An empty input register never holds off the source
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_reg_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  // Phase flips on every transfer into the result register
  a_phase_toggles: assert property (@(posedge clk) disable iff (rst)
    advance |=> (in_button_phase != $past(in_button_phase)))
    else $error("phase did not toggle on transfer");

  // A button-phase result routes to the crossing input with no delay
  a_button_result_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motor_refresh) |-> (next_channel && trigger_delay == '0))
    else $error("button result fields inconsistent");

  // A crossing-phase result goes back to the buttons without refresh
  a_cross_result_fields: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_button_phase) |=> (out_valid && !next_channel && !motor_refresh))
    else $error("crossing result fields inconsistent");

  // State holds while nothing transfers
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(period_average) && $stable(in_button_phase)))
    else $error("state changed without transfer");
`endif

endmodule
